@@ hw/rtl/rcc_pkg.sv @@
`default_nettype none

package rcc_pkg;

    // Window geometry and byte bias of the rolling checksum.
    localparam int WINDOW_LEN  = 64;
    localparam int BYTE_OFFSET = 31;

    localparam int SUM_W  = 32;
    localparam int BYTE_W = 8;

    // Sum values after reset.
    localparam logic [SUM_W-1:0] FIRST_SUM_RESET  = SUM_W'(WINDOW_LEN * BYTE_OFFSET);
    localparam logic [SUM_W-1:0] SECOND_SUM_RESET =
        SUM_W'(WINDOW_LEN * (WINDOW_LEN - 1) * BYTE_OFFSET);
    localparam logic [SUM_W-1:0] MASK_RESET = 32'h0000_7FFF;

    // Item function codes.
    localparam logic FUNC_FEED   = 1'b0;
    localparam logic FUNC_DETECT = 1'b1;

    // One result item.
    typedef struct packed {
        logic             ended_without_boundary;
        logic             boundary_found;
        logic [SUM_W-1:0] digest_value;
    } rcc_result_t;

endpackage : rcc_pkg

`default_nettype wire

@@ hw/rtl/rcc_cell.sv @@
`default_nettype none

module rcc_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      shift_en,
    input  wire logic [rcc_pkg::BYTE_W-1:0] din,
    output logic      [rcc_pkg::BYTE_W-1:0] dout
);
    import rcc_pkg::*;

    logic [BYTE_W-1:0] byte_reg;

    // One window byte; it moves one place down the row for every item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (shift_en)
        begin
            byte_reg <= din;
        end
    end

    assign dout = byte_reg;

endmodule : rcc_cell

`default_nettype wire

@@ hw/rtl/rcc_sum.sv @@
`default_nettype none

module rcc_sum (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [rcc_pkg::SUM_W-1:0]  cfg_wdata,
    input  wire logic                       in_fire,
    input  wire logic                       func,
    input  wire logic                       last_in_buffer,
    input  wire logic [rcc_pkg::BYTE_W-1:0] new_byte,
    input  wire logic [rcc_pkg::BYTE_W-1:0] old_byte,
    output rcc_pkg::rcc_result_t            result
);
    import rcc_pkg::*;

    logic [SUM_W-1:0] mask_reg;
    logic [SUM_W-1:0] first_reg;
    logic [SUM_W-1:0] first_next;
    logic [SUM_W-1:0] second_reg;
    logic [SUM_W-1:0] second_next;
    logic [SUM_W-1:0] old_term;
    rcc_result_t      result_reg;
    rcc_result_t      result_next;
    logic             found;

    // Boundary mask register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            mask_reg <= cfg_wdata;
        end
    end

    // Sum update; the window weight is a constant shift of the outgoing byte.
    always_comb
    begin
        old_term    = (SUM_W'(old_byte) + SUM_W'(BYTE_OFFSET)) * SUM_W'(WINDOW_LEN);
        first_next  = first_reg + SUM_W'(new_byte) - SUM_W'(old_byte);
        second_next = second_reg + first_next - old_term;
        found       = (func == FUNC_DETECT) && ((second_next & mask_reg) == '0);
        result_next.boundary_found         = found;
        result_next.ended_without_boundary =
            (func == FUNC_DETECT) && last_in_buffer && !found;
        result_next.digest_value           = first_next ^ second_next;
    end

    // Running sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= FIRST_SUM_RESET;
            second_reg <= SECOND_SUM_RESET;
        end
        else if (in_fire)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // Result register, loaded with each accepted item.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule : rcc_sum

`default_nettype wire

@@ hw/rtl/rolling_checksum_chunker_top.sv @@
`default_nettype none

// Rolling checksum chunker. Every input item carries one stream byte: a new item is
// accepted in every cycle in which the output register is empty or is being read, so the
// block runs at one byte per clock. The result of an item appears on the output in the
// cycle after it is accepted. The 64-byte window is a row of byte cells that shifts once
// per item; the byte leaving the last cell is the oldest one. The boundary mask resets
// to 32767; the user must write it via cfg_we/cfg_wdata only while idle, which the
// block does not check. Reset restores the empty window and the initial sums at once.
module rolling_checksum_chunker_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [rcc_pkg::SUM_W-1:0] cfg_wdata,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [7:0]                s_axis_tdata,  // [7:0] data_byte
    input  wire logic                      s_axis_tuser,  // [0] func
    input  wire logic                      s_axis_tlast,  // last_in_buffer
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic      [31:0]               m_axis_tdata,  // [31:0] digest_value
    output logic      [1:0]                m_axis_tuser   // [0] boundary_found,
                                                          // [1] ended_without_boundary
);
    import rcc_pkg::*;

    logic              in_fire;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] tap [0:WINDOW_LEN];
    rcc_result_t       result;

    // Handshake: the output register frees up when its item is taken.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    // Window as a row of byte cells.
    assign tap[0] = s_axis_tdata;

    for (genvar i = 0; i < WINDOW_LEN; i++)
    begin : g_cell
        rcc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (in_fire),
            .din      (tap[i]),
            .dout     (tap[i+1])
        );
    end

    // Checksum update and result register.
    rcc_sum u_sum (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_fire        (in_fire),
        .func           (s_axis_tuser),
        .last_in_buffer (s_axis_tlast),
        .new_byte       (s_axis_tdata),
        .old_byte       (tap[WINDOW_LEN]),
        .result         (result)
    );

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = result.digest_value;
    assign m_axis_tuser[0] = result.boundary_found;
    assign m_axis_tuser[1] = result.ended_without_boundary;

endmodule : rolling_checksum_chunker_top

`default_nettype wire

@@ hw/rtl/rcc_checker.sv @@
`default_nettype none

module rcc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);
    import rcc_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Every accepted item shows its result in the next cycle.
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted item gave no result");

    // Feed-only items never report a boundary or an unfinished buffer.
    a_feed_flags: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_FEED) |=>
            m_axis_tuser == 2'b00)
        else $error("feed-only item raised a flag");

    // A boundary and an unfinished buffer exclude each other.
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("both result flags set");

    // With the output empty, the block takes input.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule : rcc_checker

bind rolling_checksum_chunker_top rcc_checker u_rcc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
